### rtl/idfl_pkg.sv
// ----------------------------------------------------------------------------
// idfl_pkg
// Shared types and constants of the index free-list allocator.
// ----------------------------------------------------------------------------
package idfl_pkg;

    // Default pool size.
    localparam int ENTRIES_DEFAULT = 1024;

    // Fixed widths of the request and response fields.
    localparam int INDEX_FIELD_W = 10;

    // Command codes.
    localparam logic CMD_ALLOCATE = 1'b0;
    localparam logic CMD_RELEASE  = 1'b1;

    // Status codes.
    localparam logic STATUS_DONE  = 1'b0;
    localparam logic STATUS_EMPTY = 1'b1;

    typedef logic [INDEX_FIELD_W-1:0] t_index_field;

    // Controller states.
    typedef enum logic [1:0] {
        ST_INIT,
        ST_RUN,
        ST_FETCH
    } t_state;

endpackage

### rtl/idfl_if.sv
// ----------------------------------------------------------------------------
// idfl_cmd_if / idfl_rsp_if
// Valid/ready channels for allocator requests and responses.
// ----------------------------------------------------------------------------
interface idfl_cmd_if;
    logic                  valid;
    logic                  ready;
    logic                  command;
    idfl_pkg::t_index_field release_index;

    modport source (output valid, output command, output release_index, input ready);
    modport sink   (input valid, input command, input release_index, output ready);
endinterface

interface idfl_rsp_if;
    logic                  valid;
    logic                  ready;
    logic                  status;
    idfl_pkg::t_index_field granted_index;

    modport source (output valid, output status, output granted_index, input ready);
    modport sink   (input valid, input status, input granted_index, output ready);
endinterface

### rtl/index_free_list_allocator.sv
// ----------------------------------------------------------------------------
// index_free_list_allocator
// Free list of table entry indices kept in a link RAM.
// ----------------------------------------------------------------------------
// The pool of ENTRIES indices is a singly linked list held in a link RAM, with
// the head index and the head's own link kept in registers. A release or a
// failed allocate completes in ST_RUN; a successful allocate also passes
// through ST_FETCH, since the new head's link has to come back from the
// registered read port of the link RAM before the next request can be taken.
// An allocate fails with status empty when the head's link is the end marker
// or points back to the head, so the last free entry stays behind. After reset
// the block writes the initial chain 0, 1, up to ENTRIES-1, then end into the
// RAM and takes no request until that pass is done. One response comes out
// for every request; the response register lets a new request in during the
// cycle the old one leaves.
module index_free_list_allocator #(
    parameter int ENTRIES = idfl_pkg::ENTRIES_DEFAULT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    idfl_cmd_if.sink    i_cmd,
    idfl_rsp_if.source  o_rsp
);
    import idfl_pkg::*;

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int LNK_W = $clog2(ENTRIES + 1);

    t_state             r_state, n_state;
    logic [IDX_W-1:0]   r_head, n_head;
    logic [LNK_W-1:0]   r_link, n_link;
    logic [IDX_W-1:0]   r_init_cnt, n_init_cnt;
    logic               r_out_valid, n_out_valid;
    logic               r_out_status, n_out_status;
    t_index_field       r_out_granted, n_out_granted;

    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    logic [LNK_W-1:0]   wr_data;
    logic               rd_en;
    logic [IDX_W-1:0]   rd_addr;
    logic [LNK_W-1:0]   rd_data;

    logic               accept;
    logic               rel_ok;
    logic               alloc_fail;
    logic [IDX_W-1:0]   rel_idx;

    idfl_ram #(
        .WIDTH (LNK_W),
        .DEPTH (ENTRIES),
        .ADDR_W(IDX_W)
    ) u_link_ram (
        .i_clk    (i_clk),
        .i_wr_en  (wr_en),
        .i_wr_addr(wr_addr),
        .i_wr_data(wr_data),
        .i_rd_en  (rd_en),
        .i_rd_addr(rd_addr),
        .o_rd_data(rd_data)
    );

    assign i_cmd.ready = (r_state == ST_RUN) && (!r_out_valid || o_rsp.ready);
    assign accept      = i_cmd.valid && i_cmd.ready;

    assign rel_idx    = IDX_W'(i_cmd.release_index);
    assign rel_ok     = 32'(i_cmd.release_index) < ENTRIES;
    // The head's link lives in r_link; the RAM copy of the head entry is stale.
    assign alloc_fail = (r_link == LNK_W'(r_head)) || (32'(r_link) >= ENTRIES);

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.status        = r_out_status;
    assign o_rsp.granted_index = r_out_granted;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_INIT;
            r_head      <= '0;
            r_link      <= LNK_W'(1);
            r_init_cnt  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_link      <= n_link;
            r_init_cnt  <= n_init_cnt;
            r_out_valid <= n_out_valid;
        end
        r_out_status  <= n_out_status;
        r_out_granted <= n_out_granted;
    end

    always_comb begin
        n_state       = r_state;
        n_head        = r_head;
        n_link        = r_link;
        n_init_cnt    = r_init_cnt;
        n_out_valid   = r_out_valid && !o_rsp.ready;
        n_out_status  = r_out_status;
        n_out_granted = r_out_granted;
        wr_en         = 1'b0;
        wr_addr       = r_head;
        wr_data       = r_link;
        rd_en         = 1'b0;
        rd_addr       = IDX_W'(r_link);

        case (r_state)
            ST_INIT: begin
                wr_en      = 1'b1;
                wr_addr    = r_init_cnt;
                wr_data    = LNK_W'(r_init_cnt) + LNK_W'(1);
                n_init_cnt = r_init_cnt + IDX_W'(1);
                if (r_init_cnt == IDX_W'(ENTRIES - 1)) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (accept) begin
                    n_out_valid   = 1'b1;
                    n_out_status  = STATUS_DONE;
                    n_out_granted = '0;
                    if (i_cmd.command == CMD_RELEASE) begin
                        // Splice in after the head: new entry inherits the head's link.
                        if (rel_ok) begin
                            wr_en   = 1'b1;
                            wr_addr = rel_idx;
                            wr_data = r_link;
                            n_link  = LNK_W'(rel_idx);
                        end
                    end else if (alloc_fail) begin
                        n_out_status = STATUS_EMPTY;
                    end else begin
                        // Write back the old head's link and fetch the new head's.
                        wr_en         = 1'b1;
                        wr_addr       = r_head;
                        wr_data       = r_link;
                        rd_en         = 1'b1;
                        rd_addr       = IDX_W'(r_link);
                        n_head        = IDX_W'(r_link);
                        n_out_granted = INDEX_FIELD_W'(r_head);
                        n_state       = ST_FETCH;
                    end
                end
            end
            ST_FETCH: begin
                n_link  = rd_data;
                n_state = ST_RUN;
            end
            default: begin
                n_state = ST_INIT;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_head_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_head) < ENTRIES)
        else $error("free list head out of range");

    a_no_rw_collision: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (rd_en && wr_en) |-> (rd_addr != wr_addr))
        else $error("link RAM read and write hit the same entry");

    a_alloc_fetches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_cmd.command == CMD_ALLOCATE) && !alloc_fail)
            |=> (r_state == ST_FETCH) && !i_cmd.ready)
        else $error("allocate did not wait for the new head link");

    a_release_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_cmd.command == CMD_RELEASE)) |=> (r_state == ST_RUN) && r_out_valid)
        else $error("release did not complete in one cycle");
`endif

endmodule

### rtl/idfl_ram.sv
// ----------------------------------------------------------------------------
// idfl_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module idfl_ram #(
    parameter int WIDTH  = 11,
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### tb/tb_index_free_list_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_index_free_list_allocator
// Self-checking bench for the index free-list allocator. Requests are driven
// on the command channel and every transfer is run through a bit-exact free
// list predictor; responses are compared in order against the predicted
// grants. Traffic drains the pool down to the end marker, then mixes in head
// self-release, double frees and random releases under varying back-pressure.
// ----------------------------------------------------------------------------

module tb_index_free_list_allocator;

    import idfl_pkg::*;

    localparam int POOL_SIZE = ENTRIES_DEFAULT;
    localparam logic [10:0] END_MARK = 11'(POOL_SIZE);
    localparam int WATCHDOG_LIMIT = 6000;

    typedef struct packed {
        logic         status;
        t_index_field granted;
    } t_grant;

    class alloc_scoreboard;
        logic [10:0]  link_mem [POOL_SIZE];
        t_index_field head;
        t_grant       pending [$];
        int           errors;
        int           end_fails;
        int           loop_fails;

        function new();
            head = '0;
            for (int i = 0; i < POOL_SIZE; i++) begin
                link_mem[i] = 11'(i + 1);
            end
            errors     = 0;
            end_fails  = 0;
            loop_fails = 0;
        endfunction

        // Updates the free list for one accepted request and queues its grant.
        function t_grant note_request(input logic cmd, input t_index_field idx);
            t_grant      g;
            logic [10:0] lk;
            g.status  = STATUS_DONE;
            g.granted = '0;
            if (cmd == CMD_RELEASE) begin
                if (int'(idx) < POOL_SIZE) begin
                    link_mem[idx]  = link_mem[head];
                    link_mem[head] = {1'b0, idx};
                end
            end else begin
                lk = link_mem[head];
                if (lk >= END_MARK) begin
                    g.status = STATUS_EMPTY;
                    end_fails++;
                end else if (lk == {1'b0, head}) begin
                    g.status = STATUS_EMPTY;
                    loop_fails++;
                end else begin
                    g.granted = head;
                    head      = lk[INDEX_FIELD_W-1:0];
                end
            end
            pending.push_back(g);
            return g;
        endfunction

        task report_mismatch(input string what);
            $display("[%0t] response mismatch: %s", $time, what);
            errors++;
        endtask

        task check_response(input logic status, input t_index_field granted);
            t_grant g;
            if (pending.size() == 0) begin
                report_mismatch($sformatf("unexpected response status=%0b index=%0d",
                                          status, granted));
            end else begin
                g = pending.pop_front();
                if (status !== g.status) begin
                    report_mismatch($sformatf("status %0b, predicted %0b", status, g.status));
                end
                if (granted !== g.granted) begin
                    report_mismatch($sformatf("granted_index %0d, predicted %0d",
                                              granted, g.granted));
                end
            end
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;

    idfl_cmd_if cmd_if ();
    idfl_rsp_if rsp_if ();

    index_free_list_allocator #(
        .ENTRIES (POOL_SIZE)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if),
        .o_rsp   (rsp_if)
    );

    alloc_scoreboard sb;
    t_index_field    held [$];
    int              send_idle_pct;
    int              rsp_idle_pct;
    int              quiet_cycles = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Presents one request, waits for its transfer and keeps the list of
    // entries currently handed out up to date.
    task automatic push_request(input logic cmd, input t_index_field idx);
        t_grant g;
        if ($urandom_range(99) < send_idle_pct) begin
            cmd_if.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        cmd_if.valid         <= 1'b1;
        cmd_if.command       <= cmd;
        cmd_if.release_index <= idx;
        do @(posedge i_clk); while (!cmd_if.ready);
        g = sb.note_request(cmd, idx);
        if (cmd == CMD_RELEASE) begin
            for (int k = 0; k < held.size(); k++) begin
                if (held[k] == idx) begin
                    held.delete(k);
                    break;
                end
            end
        end else if (g.status == STATUS_DONE) begin
            held.push_back(g.granted);
        end
    endtask

    // Mostly well-formed traffic: allocates, and releases of entries that are
    // out. A noise share releases arbitrary indices or the head itself.
    task automatic run_traffic(input int n_items, input int alloc_pct,
                               input int noise_pct, input int stop_end_fails);
        t_index_field idx;
        int           k;
        for (int i = 0; i < n_items; i++) begin
            if (stop_end_fails > 0 && sb.end_fails >= stop_end_fails) begin
                break;
            end
            idx = t_index_field'($urandom);
            if ($urandom_range(99) < noise_pct) begin
                if ($urandom_range(3) == 0) begin
                    idx = sb.head;
                end
                push_request(CMD_RELEASE, idx);
            end else if ($urandom_range(99) < alloc_pct || held.size() == 0) begin
                push_request(CMD_ALLOCATE, idx);
            end else begin
                k = $urandom_range(held.size() - 1);
                push_request(CMD_RELEASE, held[k]);
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (rsp_if.valid && rsp_if.ready) begin
                sb.check_response(rsp_if.status, rsp_if.granted_index);
            end
            rsp_if.ready <= ($urandom_range(99) >= rsp_idle_pct);
        end else begin
            rsp_if.ready <= 1'b0;
        end
    end

    // Covers the clearing pass after reset and the longest receiver stall.
    always @(posedge i_clk) begin
        if ((cmd_if.valid && cmd_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        sb = new();
        i_rst_n              <= 1'b0;
        cmd_if.valid         <= 1'b0;
        cmd_if.command       <= CMD_ALLOCATE;
        cmd_if.release_index <= '0;
        send_idle_pct = 27;
        rsp_idle_pct  = 50;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed opening: field extremes and reuse of released entries in reverse order of release.
        push_request(CMD_ALLOCATE, 10'h000);
        push_request(CMD_ALLOCATE, 10'h3FF);
        push_request(CMD_ALLOCATE, 10'h2AA);
        push_request(CMD_ALLOCATE, 10'h155);
        push_request(CMD_RELEASE,  10'h000);
        push_request(CMD_ALLOCATE, 10'h3FF);
        push_request(CMD_RELEASE,  10'h003);
        push_request(CMD_RELEASE,  10'h001);
        push_request(CMD_ALLOCATE, 10'h000);
        push_request(CMD_ALLOCATE, 10'h000);
        push_request(CMD_ALLOCATE, 10'h000);
        push_request(CMD_RELEASE,  10'h002);
        push_request(CMD_RELEASE,  10'h004);
        push_request(CMD_ALLOCATE, 10'h3FF);

        // Drain the pool until allocation hits the end marker repeatedly.
        run_traffic(1500, 95, 0, 12);

        send_idle_pct = 50;
        rsp_idle_pct  = 27;

        // Releasing the head itself leaves it linked to itself, so the next
        // allocate must fail until another release follows.
        push_request(CMD_RELEASE, sb.head);
        push_request(CMD_ALLOCATE, 10'h000);
        if (held.size() > 0) begin
            push_request(CMD_RELEASE, held[0]);
        end
        push_request(CMD_ALLOCATE, 10'h3FF);
        push_request(CMD_ALLOCATE, 10'h000);
        push_request(CMD_ALLOCATE, 10'h000);
        run_traffic(40, 50, 15, 0);

        send_idle_pct = 0;
        rsp_idle_pct  = 0;
        run_traffic(40, 50, 10, 0);
        cmd_if.valid <= 1'b0;

        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/idfl_pkg.sv
rtl/idfl_if.sv
rtl/idfl_ram.sv
rtl/index_free_list_allocator.sv
tb/tb_index_free_list_allocator.sv
